FILE: hw/rtl/ate3_pkg.sv
package ate3_pkg;

	// Default widths of the coefficient and data words.
	localparam int COEF_WIDTH_DEF = 18;
	localparam int DATA_WIDTH_DEF = 32;

	// Register port geometry: six registers at 8-byte spacing, 64-bit data.
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	// Number of pipeline stages from accepted item to result register.
	localparam int NUM_STAGES = 5;

	// Operation selected by the command field.
	typedef enum logic [1:0] {
		CMD_POINT  = 2'd0,
		CMD_VECTOR = 2'd1,
		CMD_TENSOR = 2'd2
	} cmd_t;

	// Register indexes, taken from paddr[5:3].
	typedef enum logic [2:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_OFFX = 3'd3,
		REG_OFFY = 3'd4,
		REG_OFFZ = 3'd5
	} reg_idx_t;

	// Load enables of the pipeline registers, one per stage.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} pipe_ctl_t;

	// Row and column of each output component of the symmetric tensor.
	localparam int PAIR_R [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_C [6] = '{0, 1, 2, 1, 2, 2};

	// Input component that holds tensor element (k, l).
	localparam int TENS_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

endpackage

FILE: hw/rtl/ate3_regs.sv
module ate3_regs #(
	parameter int COEF_WIDTH = ate3_pkg::COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = ate3_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ate3_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ate3_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ate3_pkg::APB_DATA_W-1:0]   prdata,
	output logic signed [COEF_WIDTH-1:0]      coef [3][3],
	output logic signed [DATA_WIDTH-1:0]      offs [3]
);
	import ate3_pkg::*;

	localparam int RW = 3 * COEF_WIDTH;
	localparam int CF = COEF_WIDTH - 2;

	logic [RW-1:0]         row_q [3];
	logic [DATA_WIDTH-1:0] off_q [3];
	reg_idx_t              idx;
	logic                  wr_en;

	assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	// Register writes; reset loads the identity matrix and a zero offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				row_q[r] <= RW'(1) << (r * COEF_WIDTH + CF);
				off_q[r] <= '0;
			end
		end else if (wr_en) begin
			case (idx)
				REG_ROW0: row_q[0] <= pwdata[RW-1:0];
				REG_ROW1: row_q[1] <= pwdata[RW-1:0];
				REG_ROW2: row_q[2] <= pwdata[RW-1:0];
				REG_OFFX: off_q[0] <= pwdata[DATA_WIDTH-1:0];
				REG_OFFY: off_q[1] <= pwdata[DATA_WIDTH-1:0];
				REG_OFFZ: off_q[2] <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (idx)
			REG_ROW0: prdata = APB_DATA_W'(row_q[0]);
			REG_ROW1: prdata = APB_DATA_W'(row_q[1]);
			REG_ROW2: prdata = APB_DATA_W'(row_q[2]);
			REG_OFFX: prdata = APB_DATA_W'(off_q[0]);
			REG_OFFY: prdata = APB_DATA_W'(off_q[1]);
			REG_OFFZ: prdata = APB_DATA_W'(off_q[2]);
			default:  prdata = '0;
		endcase
	end

	// Unpack the coefficients; column 0 sits in the low bits of a row.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r][c] = $signed(row_q[r][c*COEF_WIDTH +: COEF_WIDTH]);
			end
			offs[r] = $signed(off_q[r]);
		end
	end

endmodule

FILE: hw/rtl/ate3_front.sv
module ate3_front #(
	parameter int COEF_WIDTH = ate3_pkg::COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = ate3_pkg::DATA_WIDTH_DEF
) (
	input  logic                                     clk,
	input  ate3_pkg::pipe_ctl_t                      ctl,
	input  ate3_pkg::cmd_t                           command,
	input  logic signed [DATA_WIDTH-1:0]             comp [6],
	input  logic signed [COEF_WIDTH-1:0]             coef [3][3],
	input  logic signed [DATA_WIDTH-1:0]             offs [3],
	output ate3_pkg::cmd_t                           cmd_s2,
	output logic signed [DATA_WIDTH+COEF_WIDTH+1:0]  m_s2 [3][3]
);
	import ate3_pkg::*;

	localparam int PW = DATA_WIDTH + COEF_WIDTH;
	localparam int MW = DATA_WIDTH + COEF_WIDTH + 2;
	localparam int CF = COEF_WIDTH - 2;

	cmd_t                   cmd_s1;
	logic signed [PW-1:0]   prod_s1 [3][3][3];
	logic signed [COEF_WIDTH-1:0] coef_sel [3][3];
	logic signed [MW-1:0]   m_sum [3][3];

	// Coefficient operand: A(c,l) for points, A(l,c) for vectors and tensors.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int l = 0; l < 3; l++) begin
				coef_sel[c][l] = (command == CMD_POINT) ? coef[c][l] : coef[l][c];
			end
		end
	end

	// Stage 1: 27 products T(k,l) * coefficient. Row k = 0 of the tensor is
	// the x, y, z input, so points and vectors use the k = 0 slots.
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			cmd_s1 <= command;
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					for (int l = 0; l < 3; l++) begin
						prod_s1[k][c][l] <= PW'(comp[TENS_IDX[k][l]] * coef_sel[c][l]);
					end
				end
			end
		end
	end

	// Sum over l; a point also adds its translation, aligned to the products.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				m_sum[k][c] = MW'(prod_s1[k][c][0]) + MW'(prod_s1[k][c][1])
					+ MW'(prod_s1[k][c][2]);
				if (cmd_s1 == CMD_POINT && k == 0) begin
					m_sum[k][c] = m_sum[k][c] + (MW'(offs[c]) <<< CF);
				end
			end
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			cmd_s2 <= cmd_s1;
			m_s2   <= m_sum;
		end
	end

endmodule

FILE: hw/rtl/ate3_back.sv
module ate3_back #(
	parameter int COEF_WIDTH = ate3_pkg::COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = ate3_pkg::DATA_WIDTH_DEF
) (
	input  logic                                       clk,
	input  ate3_pkg::pipe_ctl_t                        ctl,
	input  ate3_pkg::cmd_t                             cmd_s2,
	input  logic signed [DATA_WIDTH+COEF_WIDTH+1:0]    m_s2 [3][3],
	input  logic signed [COEF_WIDTH-1:0]               coef [3][3],
	output logic signed [DATA_WIDTH+2*COEF_WIDTH+2:0]  acc_s4 [6]
);
	import ate3_pkg::*;

	localparam int MW  = DATA_WIDTH + COEF_WIDTH + 2;
	localparam int LO  = MW / 2;
	localparam int HI  = MW - LO;
	localparam int QLW = COEF_WIDTH + LO + 1;
	localparam int QHW = COEF_WIDTH + HI;
	localparam int AW  = DATA_WIDTH + 2 * COEF_WIDTH + 3;
	localparam int CF  = COEF_WIDTH - 2;

	cmd_t                  cmd_s3;
	logic signed [QLW-1:0] q_lo_s3 [6][3];
	logic signed [QHW-1:0] q_hi_s3 [6][3];
	logic signed [MW-1:0]  pv_s3 [3];
	logic signed [QLW-1:0] q_lo [6][3];
	logic signed [QHW-1:0] q_hi [6][3];
	logic signed [AW-1:0]  acc [6];

	// Second product A(k,r) * M(k,c), with M split into an unsigned low half
	// and a signed high half to keep each multiplier narrow.
	always_comb begin
		for (int p = 0; p < 6; p++) begin
			for (int k = 0; k < 3; k++) begin
				q_lo[p][k] = QLW'(coef[k][PAIR_R[p]]
					* $signed({1'b0, m_s2[k][PAIR_C[p]][LO-1:0]}));
				q_hi[p][k] = QHW'(coef[k][PAIR_R[p]]
					* $signed(m_s2[k][PAIR_C[p]][MW-1:LO]));
			end
		end
	end

	// Stage 3 register; the point and vector sums ride along unchanged.
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			cmd_s3  <= cmd_s2;
			q_lo_s3 <= q_lo;
			q_hi_s3 <= q_hi;
			for (int c = 0; c < 3; c++) begin
				pv_s3[c] <= m_s2[0][c];
			end
		end
	end

	// Recombine the halves and sum over k. Point and vector sums are scaled
	// to the tensor's fraction so one rounding stage serves both.
	always_comb begin
		for (int p = 0; p < 6; p++) begin
			acc[p] = '0;
			case (cmd_s3)
				CMD_TENSOR: begin
					for (int k = 0; k < 3; k++) begin
						acc[p] = acc[p] + (AW'(q_hi_s3[p][k]) <<< LO) + AW'(q_lo_s3[p][k]);
					end
				end
				CMD_POINT, CMD_VECTOR: begin
					if (p < 3) begin
						acc[p] = AW'(pv_s3[p]) <<< CF;
					end
				end
				default: acc[p] = '0;
			endcase
		end
	end

	// Stage 4 register.
	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			acc_s4 <= acc;
		end
	end

endmodule

FILE: hw/rtl/ate3_round.sv
module ate3_round #(
	parameter int COEF_WIDTH = ate3_pkg::COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = ate3_pkg::DATA_WIDTH_DEF
) (
	input  logic                                       clk,
	input  ate3_pkg::pipe_ctl_t                        ctl,
	input  logic signed [DATA_WIDTH+2*COEF_WIDTH+2:0]  acc_s4 [6],
	output logic signed [DATA_WIDTH-1:0]               res_s5 [6],
	output logic                                       ovf_s5
);
	import ate3_pkg::*;

	localparam int AW = DATA_WIDTH + 2 * COEF_WIDTH + 3;
	localparam int SH = 2 * (COEF_WIDTH - 2);
	localparam int SW = AW - SH;
	localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [AW-1:0]         rnd [6];
	logic        [SW-1:0]         shr [6];
	logic signed [DATA_WIDTH-1:0] res [6];
	logic        [5:0]            sat;

	// Round half up, then saturate when the bits above the result are not
	// all copies of its sign.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			rnd[i] = acc_s4[i] + (AW'(1) <<< (SH - 1));
			shr[i] = rnd[i][AW-1:SH];
			if (!shr[i][SW-1] && (|shr[i][SW-1:DATA_WIDTH-1])) begin
				res[i] = SAT_MAX;
				sat[i] = 1'b1;
			end else if (shr[i][SW-1] && !(&shr[i][SW-1:DATA_WIDTH-1])) begin
				res[i] = SAT_MIN;
				sat[i] = 1'b1;
			end else begin
				res[i] = $signed(shr[i][DATA_WIDTH-1:0]);
				sat[i] = 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			res_s5 <= res;
			ovf_s5 <= |sat;
		end
	end

endmodule

FILE: hw/rtl/affine_transform_engine_3d_core.sv
// 3D affine transform engine. Each item is a point (A*p + t), a vector
// (transpose(A)*v) or a symmetric tensor given as six components
// (transpose(A)*T*A); results are rounded half up to Q16.16, saturated, and
// flagged in overflow, with unused fields zero. The datapath is a five-stage
// pipeline (first product, row sums, second product, recombination, rounding
// into the output register): it takes one item every cycle while item_stall
// is low; each result passes the stage registers in order to the output. A
// stall on the result side holds the output register and lets earlier
// stages fill their empty slots, so new items are taken until every stage
// is occupied. The user must write the matrix and translation through the
// register port while no item is in flight; the block does not enforce it.
module affine_transform_engine_3d_core #(
	parameter int COEF_WIDTH = ate3_pkg::COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = ate3_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ate3_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ate3_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ate3_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       command,
	input  logic signed [DATA_WIDTH-1:0]     comp_0,
	input  logic signed [DATA_WIDTH-1:0]     comp_1,
	input  logic signed [DATA_WIDTH-1:0]     comp_2,
	input  logic signed [DATA_WIDTH-1:0]     comp_3,
	input  logic signed [DATA_WIDTH-1:0]     comp_4,
	input  logic signed [DATA_WIDTH-1:0]     comp_5,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [DATA_WIDTH-1:0]     res_0,
	output logic signed [DATA_WIDTH-1:0]     res_1,
	output logic signed [DATA_WIDTH-1:0]     res_2,
	output logic signed [DATA_WIDTH-1:0]     res_3,
	output logic signed [DATA_WIDTH-1:0]     res_4,
	output logic signed [DATA_WIDTH-1:0]     res_5,
	output logic                             overflow
);
	import ate3_pkg::*;

	localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [COEF_WIDTH-1:0]                coef [3][3];
	logic signed [DATA_WIDTH-1:0]                offs [3];
	logic signed [DATA_WIDTH-1:0]                comp [6];
	logic signed [DATA_WIDTH-1:0]                res_s5 [6];
	logic signed [DATA_WIDTH+COEF_WIDTH+1:0]     m_s2 [3][3];
	logic signed [DATA_WIDTH+2*COEF_WIDTH+2:0]   acc_s4 [6];
	cmd_t                                        cmd_s2;
	logic                                        ovf_s5;
	logic [NUM_STAGES-1:0]                       vld_q;
	logic [NUM_STAGES-1:0]                       rdy;
	pipe_ctl_t                                   ctl;

	assign pready = 1'b1;

	assign comp[0] = comp_0;
	assign comp[1] = comp_1;
	assign comp[2] = comp_2;
	assign comp[3] = comp_3;
	assign comp[4] = comp_4;
	assign comp[5] = comp_5;

	// A stage can load when it is empty or its content moves on this cycle.
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !result_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctl.ld_s1 = rdy[0] && item_valid;
	assign ctl.ld_s2 = rdy[1] && vld_q[0];
	assign ctl.ld_s3 = rdy[2] && vld_q[1];
	assign ctl.ld_s4 = rdy[3] && vld_q[2];
	assign ctl.ld_s5 = rdy[4] && vld_q[3];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= item_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign item_stall   = !rdy[0];
	assign result_valid = vld_q[NUM_STAGES-1];

	ate3_regs #(
		.COEF_WIDTH (COEF_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef    (coef),
		.offs    (offs)
	);

	ate3_front #(
		.COEF_WIDTH (COEF_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk     (clk),
		.ctl     (ctl),
		.command (cmd_t'(command)),
		.comp    (comp),
		.coef    (coef),
		.offs    (offs),
		.cmd_s2  (cmd_s2),
		.m_s2    (m_s2)
	);

	ate3_back #(
		.COEF_WIDTH (COEF_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk     (clk),
		.ctl     (ctl),
		.cmd_s2  (cmd_s2),
		.m_s2    (m_s2),
		.coef    (coef),
		.acc_s4  (acc_s4)
	);

	ate3_round #(
		.COEF_WIDTH (COEF_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_round (
		.clk     (clk),
		.ctl     (ctl),
		.acc_s4  (acc_s4),
		.res_s5  (res_s5),
		.ovf_s5  (ovf_s5)
	);

	assign res_0    = res_s5[0];
	assign res_1    = res_s5[1];
	assign res_2    = res_s5[2];
	assign res_3    = res_s5[3];
	assign res_4    = res_s5[4];
	assign res_5    = res_s5[5];
	assign overflow = ovf_s5;

	// Input is held back only when every stage holds an item.
	a_stall_only_when_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		item_stall |-> (&vld_q)
	) else $error("input stalled while a pipeline stage was empty");

	// An item in the last compute stage reaches the output once it may move.
	a_item_advances: assert property (
		@(posedge clk) disable iff (!arst_n)
		(vld_q[NUM_STAGES-2] && rdy[NUM_STAGES-1]) |=> result_valid
	) else $error("item lost between the last stage and the output register");

	// A flagged result carries at least one saturated component.
	a_overflow_saturates: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && overflow) |->
			(res_0 == SAT_MAX || res_0 == SAT_MIN || res_1 == SAT_MAX || res_1 == SAT_MIN ||
			 res_2 == SAT_MAX || res_2 == SAT_MIN || res_3 == SAT_MAX || res_3 == SAT_MIN ||
			 res_4 == SAT_MAX || res_4 == SAT_MIN || res_5 == SAT_MAX || res_5 == SAT_MIN)
	) else $error("overflow flagged without a saturated component");

endmodule

FILE: tb/sv/affine_transform_engine_3d_core_tb.sv
module affine_transform_engine_3d_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ate3_pkg::*;

	localparam int CW = COEF_WIDTH_DEF;
	localparam int DW = DATA_WIDTH_DEF;
	localparam int FRAC = CW - 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// Q2.16 coefficient codes used by the directed cases.
	localparam logic [CW-1:0] COEF_ONE = 18'h10000;
	localparam logic [CW-1:0] COEF_HALF = 18'h08000;
	localparam logic [CW-1:0] COEF_MAX = 18'h1FFFF;
	localparam logic [CW-1:0] COEF_MIN = 18'h20000;
	localparam logic [CW-1:0] COEF_ZERO = 18'h00000;

	localparam logic [DW-1:0] DATA_MAX = 32'h7FFFFFFF;
	localparam logic [DW-1:0] DATA_MIN = 32'h80000000;

	localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (DW - 1)) - 128'sd1;
	localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

	// One result item: six components and the saturation flag.
	typedef struct packed {
		logic ovf;
		logic [5:0][DW-1:0] r;
	} xform_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] command = CMD_POINT;
	logic signed [DW-1:0] comp_0 = '0;
	logic signed [DW-1:0] comp_1 = '0;
	logic signed [DW-1:0] comp_2 = '0;
	logic signed [DW-1:0] comp_3 = '0;
	logic signed [DW-1:0] comp_4 = '0;
	logic signed [DW-1:0] comp_5 = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [DW-1:0] res_0;
	logic signed [DW-1:0] res_1;
	logic signed [DW-1:0] res_2;
	logic signed [DW-1:0] res_3;
	logic signed [DW-1:0] res_4;
	logic signed [DW-1:0] res_5;
	logic overflow;

	// Local copy of the matrix and translation as the block should hold them.
	logic signed [CW-1:0] mat_coef [3][3];
	logic signed [DW-1:0] trans_off [3];

	xform_t transformed_q [$];
	int mismatches = 0;
	int cycle_count = 0;
	int stall_pct = 25;
	int stall_run = 0;
	logic stalling = 1'b0;
	int n_point = 0;
	int n_vector = 0;
	int n_tensor = 0;
	int n_unknown = 0;
	int n_saturated = 0;
	int n_reg_writes = 0;

	affine_transform_engine_3d_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.comp_0(comp_0),
		.comp_1(comp_1),
		.comp_2(comp_2),
		.comp_3(comp_3),
		.comp_4(comp_4),
		.comp_5(comp_5),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.res_0(res_0),
		.res_1(res_1),
		.res_2(res_2),
		.res_3(res_3),
		.res_4(res_4),
		.res_5(res_5),
		.overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Round half up by sh fraction bits, then saturate to the data width.
	function automatic logic [DW-1:0] round_sat(input logic signed [127:0] acc, input int sh,
			inout logic ovf);
		logic signed [127:0] q;
		q = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
		if (q > SAT_HI) begin
			ovf = 1'b1;
			return SAT_HI[DW-1:0];
		end
		if (q < SAT_LO) begin
			ovf = 1'b1;
			return SAT_LO[DW-1:0];
		end
		return q[DW-1:0];
	endfunction

	// Exact transform of one item with the current matrix and translation.
	function automatic xform_t transform_item(input logic [1:0] cmd,
			input logic [5:0][DW-1:0] d);
		xform_t res;
		logic signed [127:0] acc;
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic signed [127:0] c;
		logic ovf;
		int r;
		int cc;
		res = '0;
		ovf = 1'b0;
		if (cmd == CMD_POINT || cmd == CMD_VECTOR) begin
			for (int i = 0; i < 3; i++) begin
				acc = '0;
				for (int k = 0; k < 3; k++) begin
					a = (cmd == CMD_POINT) ? mat_coef[i][k] : mat_coef[k][i];
					b = $signed(d[k]);
					acc = acc + a * b;
				end
				if (cmd == CMD_POINT) begin
					a = trans_off[i];
					acc = acc + (a <<< FRAC);
				end
				res.r[i] = round_sat(acc, FRAC, ovf);
			end
		end else if (cmd == CMD_TENSOR) begin
			for (int i = 0; i < 6; i++) begin
				r = PAIR_R[i];
				cc = PAIR_C[i];
				acc = '0;
				for (int k = 0; k < 3; k++) begin
					for (int l = 0; l < 3; l++) begin
						a = $signed(d[TENS_IDX[k][l]]);
						b = mat_coef[k][r];
						c = mat_coef[l][cc];
						acc = acc + a * b * c;
					end
				end
				res.r[i] = round_sat(acc, 2 * FRAC, ovf);
			end
		end
		res.ovf = ovf;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("ERROR %0t ns: %s got %h, expected %h", $time, field, got, want);
		mismatches++;
	endtask

	// Receiver: stall in runs of random length; stall_pct sets how often.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 8);
			stalling = ($urandom_range(0, 99) < stall_pct);
		end else begin
			stall_run--;
		end
		result_stall <= stalling;
	end

	// Outputs are stable between edges, so a transfer seen at the falling
	// edge completes at the next rising edge.
	always @(negedge clk) begin
		xform_t got;
		xform_t want;
		if (arst_n && result_valid && !result_stall) begin
			got.r[0] = res_0;
			got.r[1] = res_1;
			got.r[2] = res_2;
			got.r[3] = res_3;
			got.r[4] = res_4;
			got.r[5] = res_5;
			got.ovf = overflow;
			if (transformed_q.size() == 0) begin
				report_mismatch("unexpected result, res_0", got.r[0], '0);
			end else begin
				want = transformed_q.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (got.r[i] !== want.r[i])
						report_mismatch($sformatf("res_%0d", i), got.r[i], want.r[i]);
				end
				if (got.ovf !== want.ovf)
					report_mismatch("overflow", DW'(got.ovf), DW'(want.ovf));
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
			transformed_q.size());
		$display("affine_transform_engine_3d_core regression: fail");
		$finish;
	end

	// Called at a rising edge; returns at the edge where the item transfers.
	task automatic send_item(input logic [1:0] cmd, input logic [DW-1:0] c0, c1, c2, c3, c4,
			c5);
		xform_t want;
		command <= cmd;
		comp_0 <= c0;
		comp_1 <= c1;
		comp_2 <= c2;
		comp_3 <= c3;
		comp_4 <= c4;
		comp_5 <= c5;
		item_valid <= 1'b1;
		@(negedge clk);
		while (item_stall)
			@(negedge clk);
		@(posedge clk);
		want = transform_item(cmd, {c5, c4, c3, c2, c1, c0});
		transformed_q.push_back(want);
		if (want.ovf)
			n_saturated++;
		case (cmd)
			CMD_POINT: n_point++;
			CMD_VECTOR: n_vector++;
			CMD_TENSOR: n_tensor++;
			default: n_unknown++;
		endcase
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait until every result is in and the pipeline has emptied.
	task automatic drain_pipeline();
		item_valid <= 1'b0;
		while (transformed_q.size() != 0)
			@(posedge clk);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			REG_ROW0, REG_ROW1, REG_ROW2: begin
				for (int c = 0; c < 3; c++)
					mat_coef[int'(idx)][c] = value[c*CW +: CW];
			end
			REG_OFFX, REG_OFFY, REG_OFFZ: trans_off[int'(idx) - int'(REG_OFFX)] = value[DW-1:0];
			default: ;
		endcase
		n_reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Packs three coefficients into a row word; the unused upper bits are random.
	function automatic logic [APB_DATA_W-1:0] pack_row(input logic [CW-1:0] c0, c1, c2);
		logic [APB_DATA_W-1:0] v;
		v = {$urandom, $urandom};
		v[3*CW-1:0] = {c2, c1, c0};
		return v;
	endfunction

	// Loads the whole transform once the block is idle.
	task automatic load_transform(input logic [APB_DATA_W-1:0] r0, r1, r2,
			input logic [DW-1:0] ox, oy, oz);
		drain_pipeline();
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
		write_reg(REG_OFFX, {$urandom, ox});
		write_reg(REG_OFFY, {$urandom, oy});
		write_reg(REG_OFFZ, {$urandom, oz});
	endtask

	function automatic logic [CW-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0, 1: return CW'($urandom);
			2: return COEF_ONE;
			3: return COEF_ZERO;
			4: return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
			default: return CW'($urandom_range(0, 4095)) - CW'(2048);
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0, 1, 2: return $urandom;
			3, 4: return DW'($urandom_range(0, 2097152)) - DW'(1048576);
			5: return DATA_MAX;
			6: return DATA_MIN;
			default: return DW'($urandom_range(0, 2)) - DW'(1);
		endcase
	endfunction

	function automatic logic [1:0] rand_command();
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4: return CMD_POINT;
			5, 6, 7, 8, 9: return CMD_VECTOR;
			15: return CMD_UNKNOWN;
			default: return CMD_TENSOR;
		endcase
	endfunction

	// Reset transform is the identity: points, vectors and tensors pass data through; unknown commands give zeros.
	task automatic test_identity_defaults();
		send_item(CMD_POINT, '0, '0, '0, '0, '0, '0);
		send_item(CMD_POINT, DATA_MAX, DATA_MIN, 32'h00010000, $urandom, $urandom, $urandom);
		send_item(CMD_VECTOR, DATA_MIN, DATA_MAX, 32'hFFFFFFFF, $urandom, $urandom, $urandom);
		send_item(CMD_TENSOR, DATA_MAX, DATA_MIN, 32'h12345678, 32'hFFFFFFFF, 32'h1,
			32'h80000001);
		idle_cycles(2);
		send_item(CMD_UNKNOWN, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
		send_item(CMD_UNKNOWN, DATA_MIN, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Halves land exactly on the rounding point, both positive and negative.
	task automatic test_rounding();
		load_transform(pack_row(COEF_HALF, COEF_ZERO, COEF_ZERO),
			pack_row(COEF_ZERO, COEF_HALF, COEF_ZERO),
			pack_row(COEF_ZERO, COEF_ZERO, COEF_HALF), 32'h1, 32'hFFFFFFFF, '0);
		send_item(CMD_POINT, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFD, '0, '0, '0);
		send_item(CMD_VECTOR, 32'h3, 32'hFFFFFFFE, DATA_MAX, '0, '0, '0);
		send_item(CMD_TENSOR, 32'h2, 32'h1, 32'hFFFFFFFE, 32'hFFFFFFFA, 32'h6, 32'h3);
		send_item(CMD_TENSOR, DATA_MIN, DATA_MAX, 32'h5, 32'h3, 32'hFFFFFFFF, 32'h7);
	endtask

	// Largest and most negative coefficients drive every path into saturation.
	task automatic test_saturation();
		load_transform(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_row(COEF_MAX, COEF_MAX, COEF_MAX), DATA_MAX, DATA_MAX, DATA_MIN);
		send_item(CMD_POINT, DATA_MAX, DATA_MAX, DATA_MAX, '0, '0, '0);
		send_item(CMD_POINT, DATA_MIN, DATA_MIN, DATA_MIN, '0, '0, '0);
		send_item(CMD_VECTOR, DATA_MAX, '0, '0, '0, '0, '0);
		send_item(CMD_TENSOR, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
		load_transform(pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
			pack_row(COEF_MIN, COEF_ONE, COEF_MIN),
			pack_row(COEF_MIN, COEF_MIN, COEF_MIN), DATA_MIN, DATA_MIN, DATA_MAX);
		send_item(CMD_POINT, DATA_MIN, DATA_MAX, DATA_MIN, '0, '0, '0);
		send_item(CMD_VECTOR, DATA_MIN, DATA_MIN, DATA_MIN, '0, '0, '0);
		send_item(CMD_TENSOR, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
		send_item(CMD_TENSOR, DATA_MIN, '0, '0, DATA_MAX, '0, DATA_MIN);
	endtask

	// Phases of random items, each with its own transform, sender gaps and stalls.
	task automatic test_random_stream();
		int gap_max;
		int burst_left;
		logic [CW-1:0] cf [9];
		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < 9; i++) begin
				case (p % 4)
					1: cf[i] = COEF_MAX;
					2: cf[i] = COEF_MIN;
					default: cf[i] = rand_coef();
				endcase
			end
			case (p % 4)
				1: load_transform(pack_row(cf[0], cf[1], cf[2]), pack_row(cf[3], cf[4], cf[5]),
					pack_row(cf[6], cf[7], cf[8]), DATA_MAX, DATA_MAX, DATA_MAX);
				2: load_transform(pack_row(cf[0], cf[1], cf[2]), pack_row(cf[3], cf[4], cf[5]),
					pack_row(cf[6], cf[7], cf[8]), DATA_MIN, DATA_MIN, DATA_MIN);
				default: load_transform(pack_row(cf[0], cf[1], cf[2]),
					pack_row(cf[3], cf[4], cf[5]), pack_row(cf[6], cf[7], cf[8]), rand_comp(),
					rand_comp(), rand_comp());
			endcase
			gap_max = (p % 3) * 3;
			stall_pct = ((p / 2) % 3) * 35;
			burst_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (burst_left == 0) begin
					idle_cycles($urandom_range(0, gap_max));
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;
				send_item(rand_command(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), rand_comp());
			end
		end
	endtask

	initial begin
		// Assert reset after every process has started, so the falling edge is seen.
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset values of the transform.
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++)
				mat_coef[r][c] = (r == c) ? COEF_ONE : COEF_ZERO;
			trans_off[r] = '0;
		end
		test_identity_defaults();
		test_rounding();
		test_saturation();
		test_random_stream();
		stall_pct = 25;
		drain_pipeline();
		repeat (NUM_STAGES + 5) @(posedge clk);
		$display("Checked %0d points, %0d vectors, %0d tensors and %0d unknown commands;",
			n_point, n_vector, n_tensor, n_unknown);
		$display("%0d register writes, %0d saturating results, %0d mismatches.", n_reg_writes,
			n_saturated, mismatches);
		if (mismatches == 0) begin
			$display("affine_transform_engine_3d_core regression: pass");
		end else begin
			$display("affine_transform_engine_3d_core regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/ate3_pkg.sv
hw/rtl/ate3_regs.sv
hw/rtl/ate3_front.sv
hw/rtl/ate3_back.sv
hw/rtl/ate3_round.sv
hw/rtl/affine_transform_engine_3d_core.sv
tb/sv/affine_transform_engine_3d_core_tb.sv
